/* src/svf_pkg.sv */
// ---------------------------------------------------------------------------
// svf_pkg: shared types and constants
// frame descriptors, configuration layout, drive command codes and crc16
// ---------------------------------------------------------------------------
package svf_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_RPM_PER_US   = 3'd0;
    localparam logic [2:0] CFG_RPM_MIN      = 3'd1;
    localparam logic [2:0] CFG_RPM_MAX      = 3'd2;
    localparam logic [2:0] CFG_MIN_STEP_RPM = 3'd3;
    localparam logic [2:0] CFG_HOLD_MS      = 3'd4;
    localparam logic [2:0] CFG_SAMPLE_MS    = 3'd5;
    localparam logic [2:0] CFG_DEVICE_ID    = 3'd6;
    localparam logic [2:0] CFG_START_RPM    = 3'd7;

    // configuration reset values
    localparam logic [9:0]  RST_RPM_PER_US   = 10'd126;
    localparam logic [15:0] RST_RPM_MIN      = 16'd8000;
    localparam logic [15:0] RST_RPM_MAX      = 16'd24000;
    localparam logic [15:0] RST_MIN_STEP_RPM = 16'd250;
    localparam logic [15:0] RST_HOLD_MS      = 16'd1000;
    localparam logic [15:0] RST_SAMPLE_MS    = 16'd100;
    localparam logic [7:0]  RST_DEVICE_ID    = 8'd1;
    localparam logic [15:0] RST_START_RPM    = 16'd6000;

    // drive commands and data
    localparam logic [7:0] CMD_SPEED   = 8'h05;
    localparam logic [7:0] CMD_CONTROL = 8'h03;
    localparam logic [7:0] CMD_STATUS  = 8'h04;
    localparam logic [7:0] CTL_STOP    = 8'h08;
    localparam logic [7:0] CTL_RUN     = 8'h01;
    localparam logic [7:0] STATUS_DATA = 8'h00;

    // smoothing filter, power-of-two divisor
    localparam int FILTER_DIVISOR = 16;
    localparam int FILTER_SHIFT   = $clog2(FILTER_DIVISOR);

    localparam logic [15:0] PULSE_TIMEOUT_US = 16'd252;

    // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x below 2^19
    localparam logic [17:0] DIV3_RECIP = 18'd174763;
    localparam int          DIV3_SHIFT = 19;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [9:0]  rpm_per_us;
        logic [15:0] rpm_min;
        logic [15:0] rpm_max;
        logic [15:0] min_step_rpm;
        logic [15:0] hold_ms;
        logic [15:0] sample_period_ms;
        logic [7:0]  device_id;
        logic [15:0] start_rpm;
    } cfg_regs_t;

    typedef struct packed {
        logic [7:0] cmd;
        logic       two_data;
        logic [7:0] d0;
        logic [7:0] d1;
        logic       last;
    } frame_desc_t;

    // modbus crc16, one byte, bit by bit
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* src/svf_ifs.sv */
// ---------------------------------------------------------------------------
// svf channel interfaces
// sample input, frame byte output and configuration write channels
// ---------------------------------------------------------------------------
interface svf_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [7:0]  pulse_width;
    logic        pulse_level;
    logic        run_level;

    modport source (output valid, now_ms, pulse_width, pulse_level, run_level, input ready);
    modport sink   (input valid, now_ms, pulse_width, pulse_level, run_level, output ready);
endinterface

interface svf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       last;

    modport source (output valid, frame_byte, frame_end, last, input ready);
    modport sink   (input valid, frame_byte, frame_end, last, output ready);
endinterface

interface svf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/svf_front.sv */
// ---------------------------------------------------------------------------
// svf_front: sample sequencer
// takes one sample, updates speed state and queues frame descriptors
// ---------------------------------------------------------------------------
module svf_front
    import svf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_regs_t     cfg,
    svf_sample_if.sink    samples,
    output logic          push,
    output frame_desc_t   push_desc,
    input  logic          q_full
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SAMPLE = 4'd1;
    localparam logic [3:0] ST_FILT   = 4'd2;
    localparam logic [3:0] ST_REQ    = 4'd3;
    localparam logic [3:0] ST_FREQ   = 4'd4;
    localparam logic [3:0] ST_SPEED  = 4'd5;
    localparam logic [3:0] ST_RUN    = 4'd6;
    localparam logic [3:0] ST_RUNCMD = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [31:0] last_sample_reg, last_sample_next;
    logic [31:0] last_update_reg, last_update_next;
    logic [17:0] smoothed_reg, smoothed_next;
    logic [15:0] sent_reg, sent_next;
    logic        running_reg, running_next;
    logic        run_seen_reg, run_seen_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        ret_start_reg, ret_start_next;

    logic [31:0] now_reg, now_next;
    logic [7:0]  pw_reg, pw_next;
    logic        plev_reg, plev_next;
    logic        rlev_reg, rlev_next;
    logic [17:0] raw_reg, raw_next;
    logic [15:0] req_reg, req_next;
    logic [18:0] prod5_reg, prod5_next;
    logic [17:0] quot_reg, quot_next;
    frame_desc_t pend_reg, pend_next;

    logic [31:0]        elapsed_sample;
    logic [31:0]        elapsed_update;
    logic               do_sample;
    logic               pw_zero;
    logic [17:0]        gain_prod;
    logic [18:0]        raw_sum;
    logic [17:0]        raw_sat;
    logic signed [18:0] filt_diff;
    logic signed [18:0] filt_delta;
    logic signed [18:0] filt_sum;
    logic [17:0]        smooth_new;
    logic               held;
    logic [16:0]        step_diff;
    logic [16:0]        step_abs;
    logic               step_small;
    logic [36:0]        quot_full;
    logic [15:0]        freq;
    logic [3:0]         ret_state;
    logic               emit_req;
    logic               emit_room;
    logic               emit_go;
    frame_desc_t        new_desc;

    assign samples.ready = (state_reg == ST_IDLE);

    // datapath
    always_comb
    begin
        elapsed_sample = now_reg - last_sample_reg;
        elapsed_update = now_reg - last_update_reg;
        do_sample      = elapsed_sample > {16'd0, cfg.sample_period_ms};
        pw_zero        = (pw_reg == 8'd0) || ({8'd0, pw_reg} > PULSE_TIMEOUT_US);
        gain_prod      = {8'd0, cfg.rpm_per_us} * {10'd0, pw_reg};
        raw_sum        = {3'd0, cfg.rpm_min} + {1'b0, gain_prod};
        raw_sat        = raw_sum[18] ? 18'h3FFFF : raw_sum[17:0];
        filt_diff      = signed'({1'b0, raw_reg}) - signed'({1'b0, smoothed_reg});
        // truncate toward zero
        if (filt_diff < 0)
            filt_delta = (filt_diff + 19'(FILTER_DIVISOR - 1)) >>> FILTER_SHIFT;
        else
            filt_delta = filt_diff >>> FILTER_SHIFT;
        filt_sum       = signed'({1'b0, smoothed_reg}) + filt_delta;
        smooth_new     = filt_sum[17:0];
        held           = elapsed_update < {16'd0, cfg.hold_ms};
        step_diff      = {1'b0, sent_reg} - {1'b0, req_reg};
        step_abs       = step_diff[16] ? (17'd0 - step_diff) : step_diff;
        step_small     = step_abs < {1'b0, cfg.min_step_rpm};
        quot_full      = {18'd0, prod5_reg} * {19'd0, DIV3_RECIP};
        freq           = (quot_reg[17:16] != 2'd0) ? 16'hFFFF : quot_reg[15:0];
        ret_state      = ret_start_reg ? ST_RUNCMD : ST_RUN;
    end

    always_comb
    begin
        state_next       = state_reg;
        last_sample_next = last_sample_reg;
        last_update_next = last_update_reg;
        smoothed_next    = smoothed_reg;
        sent_next        = sent_reg;
        running_next     = running_reg;
        run_seen_next    = run_seen_reg;
        pend_valid_next  = pend_valid_reg;
        ret_start_next   = ret_start_reg;
        now_next         = now_reg;
        pw_next          = pw_reg;
        plev_next        = plev_reg;
        rlev_next        = rlev_reg;
        raw_next         = raw_reg;
        req_next         = req_reg;
        prod5_next       = prod5_reg;
        quot_next        = quot_reg;
        pend_next        = pend_reg;
        emit_req         = 1'b0;
        new_desc         = '0;
        push             = 1'b0;
        push_desc        = pend_reg;
        // a new frame fits when nothing is held back or the held one can move on
        emit_room        = !pend_valid_reg || !q_full;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    now_next   = samples.now_ms;
                    pw_next    = samples.pulse_width;
                    plev_next  = samples.pulse_level;
                    rlev_next  = samples.run_level;
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE:
            begin
                ret_start_next = 1'b0;
                if (do_sample)
                begin
                    last_sample_next = now_reg;
                    if (pw_zero)
                    begin
                        req_next   = plev_reg ? cfg.rpm_max : cfg.rpm_min;
                        state_next = ST_REQ;
                    end
                    else
                    begin
                        raw_next   = raw_sat;
                        state_next = ST_FILT;
                    end
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_FILT:
            begin
                smoothed_next = smooth_new;
                req_next      = (smooth_new[17:16] != 2'd0) ? 16'hFFFF : smooth_new[15:0];
                state_next    = ST_REQ;
            end
            ST_REQ:
            begin
                state_next = ret_state;
                if (!held)
                begin
                    last_update_next = now_reg;
                    if (running_reg && !step_small)
                    begin
                        sent_next  = req_reg;
                        prod5_next = {1'b0, req_reg, 2'b00} + {3'd0, req_reg};
                        state_next = ST_FREQ;
                    end
                end
            end
            ST_FREQ:
            begin
                quot_next  = quot_full[DIV3_SHIFT +: 18];
                state_next = ST_SPEED;
            end
            ST_SPEED:
            begin
                emit_req          = 1'b1;
                new_desc.cmd      = CMD_SPEED;
                new_desc.two_data = 1'b1;
                new_desc.d0       = freq[15:8];
                new_desc.d1       = freq[7:0];
                if (emit_room)
                    state_next = ret_state;
            end
            ST_RUN:
            begin
                if (rlev_reg != run_seen_reg)
                begin
                    emit_req     = 1'b1;
                    new_desc.cmd = rlev_reg ? CMD_CONTROL : CMD_STATUS;
                    new_desc.d0  = rlev_reg ? CTL_STOP : STATUS_DATA;
                    if (emit_room)
                    begin
                        run_seen_next = rlev_reg;
                        if (rlev_reg)
                        begin
                            running_next = 1'b0;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            // start sequence: forced speed request, then run command
                            running_next     = 1'b1;
                            last_update_next = 32'd0;
                            req_next         = cfg.start_rpm;
                            ret_start_next   = 1'b1;
                            state_next       = ST_REQ;
                        end
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RUNCMD:
            begin
                emit_req     = 1'b1;
                new_desc.cmd = CMD_CONTROL;
                new_desc.d0  = CTL_RUN;
                if (emit_room)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // flush held-back frame, marked as the sample's last
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!q_full)
                begin
                    push            = 1'b1;
                    push_desc.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // one frame is held back so the final one can carry the last mark
        emit_go = emit_req && emit_room;
        if (emit_go)
        begin
            push            = pend_valid_reg;
            pend_next       = new_desc;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_sample_reg <= 32'd0;
            last_update_reg <= 32'd0;
            smoothed_reg    <= 18'd0;
            sent_reg        <= 16'd0;
            running_reg     <= 1'b0;
            run_seen_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
            ret_start_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_sample_reg <= last_sample_next;
            last_update_reg <= last_update_next;
            smoothed_reg    <= smoothed_next;
            sent_reg        <= sent_next;
            running_reg     <= running_next;
            run_seen_reg    <= run_seen_next;
            pend_valid_reg  <= pend_valid_next;
            ret_start_reg   <= ret_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        pw_reg    <= pw_next;
        plev_reg  <= plev_next;
        rlev_reg  <= rlev_next;
        raw_reg   <= raw_next;
        req_reg   <= req_next;
        prod5_reg <= prod5_next;
        quot_reg  <= quot_next;
        pend_reg  <= pend_next;
    end

endmodule

/* src/svf_fifo.sv */
// ---------------------------------------------------------------------------
// svf_fifo: frame descriptor queue
// short register queue between sequencer and serialiser
// ---------------------------------------------------------------------------
module svf_fifo
    import svf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_desc_t push_data,
    output logic        full,
    input  logic        pop,
    output frame_desc_t pop_data,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_desc_t        store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* src/svf_back.sv */
// ---------------------------------------------------------------------------
// svf_back: frame serialiser
// expands a descriptor into frame bytes with a trailing modbus crc16
// ---------------------------------------------------------------------------
module svf_back
    import svf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   device_id,
    input  frame_desc_t  desc,
    input  logic         q_empty,
    output logic         pop,
    svf_frame_if.source  frames
);

    localparam logic [2:0] IDX_ID     = 3'd0;
    localparam logic [2:0] IDX_CMD    = 3'd1;
    localparam logic [2:0] IDX_LEN    = 3'd2;
    localparam logic [2:0] IDX_D0     = 3'd3;
    localparam logic [2:0] IDX_D1     = 3'd4;
    localparam logic [2:0] IDX_CRC_LO = 3'd5;
    localparam logic [2:0] IDX_CRC_HI = 3'd6;

    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    frame_desc_t desc_reg, desc_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;
    logic        last_reg, last_next;

    logic        adv;
    logic [7:0]  cur_byte;

    assign frames.valid      = out_valid_reg;
    assign frames.frame_byte = byte_reg;
    assign frames.frame_end  = end_reg;
    assign frames.last       = last_reg;

    always_comb
    begin
        unique case (idx_reg)
            IDX_ID:     cur_byte = device_id;
            IDX_CMD:    cur_byte = desc_reg.cmd;
            IDX_LEN:    cur_byte = desc_reg.two_data ? 8'd2 : 8'd1;
            IDX_D0:     cur_byte = desc_reg.d0;
            IDX_D1:     cur_byte = desc_reg.d1;
            IDX_CRC_LO: cur_byte = crc_reg[7:0];
            IDX_CRC_HI: cur_byte = crc_reg[15:8];
            default:    cur_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        desc_next      = desc_reg;
        crc_next       = crc_reg;
        byte_next      = byte_reg;
        end_next       = end_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        adv            = busy_reg && (!out_valid_reg || frames.ready);

        if (out_valid_reg && frames.ready)
            out_valid_next = 1'b0;

        if (!busy_reg)
        begin
            if (!q_empty)
            begin
                pop       = 1'b1;
                desc_next = desc;
                idx_next  = IDX_ID;
                crc_next  = CRC_INIT;
                busy_next = 1'b1;
            end
        end
        else if (adv)
        begin
            out_valid_next = 1'b1;
            byte_next      = cur_byte;
            end_next       = (idx_reg == IDX_CRC_HI);
            last_next      = (idx_reg == IDX_CRC_HI) && desc_reg.last;
            // crc covers header and data only
            if (idx_reg < IDX_CRC_LO)
                crc_next = crc16_byte(crc_reg, cur_byte);
            if (idx_reg == IDX_D0 && !desc_reg.two_data)
                idx_next = IDX_CRC_LO;
            else
                idx_next = idx_reg + 3'd1;
            if (idx_reg == IDX_CRC_HI)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= IDX_ID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        crc_reg  <= crc_next;
        byte_reg <= byte_next;
        end_reg  <= end_next;
        last_reg <= last_next;
    end

endmodule

/* src/pwm_spindle_speed_to_vfd_frames.sv */
// ---------------------------------------------------------------------------
// pwm_spindle_speed_to_vfd_frames: spindle pwm to drive frame converter
// turns pulse width samples and the run pin into modbus style drive frames
// ---------------------------------------------------------------------------
//
// channel   role     payload                                         transaction
// samples   sink     now_ms[31:0] pulse_width[7:0] pulse_level        valid & ready
//                    run_level
// frames    source   frame_byte[7:0] frame_end last                   valid & ready
// cfg       sink     index[2:0] data[15:0]                            valid & ready
//
// a sample holds the sequencer until its frames are queued, plus any wait on a
// full queue, and no new sample is taken before then; each frame leaves the
// serialiser one byte a cycle while the receiver keeps ready high
// reset (rst_n, async, active low) restores the register defaults and clears
// speed state, queue and output stage; no clearing pass
// output stalls back up through the queue and then hold the sequencer

module pwm_spindle_speed_to_vfd_frames
    import svf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    svf_sample_if.sink  samples,
    svf_frame_if.source frames,
    svf_cfg_if.sink     cfg
);

    cfg_regs_t   cfg_reg, cfg_next;

    logic        fifo_push;
    logic        fifo_full;
    logic        fifo_pop;
    logic        fifo_empty;
    frame_desc_t fifo_in;
    frame_desc_t fifo_out;

    // configuration port never stalls
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RPM_PER_US:   cfg_next.rpm_per_us       = cfg.data[9:0];
                CFG_RPM_MIN:      cfg_next.rpm_min          = cfg.data;
                CFG_RPM_MAX:      cfg_next.rpm_max          = cfg.data;
                CFG_MIN_STEP_RPM: cfg_next.min_step_rpm     = cfg.data;
                CFG_HOLD_MS:      cfg_next.hold_ms          = cfg.data;
                CFG_SAMPLE_MS:    cfg_next.sample_period_ms = cfg.data;
                CFG_DEVICE_ID:    cfg_next.device_id        = cfg.data[7:0];
                CFG_START_RPM:    cfg_next.start_rpm        = cfg.data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rpm_per_us       <= RST_RPM_PER_US;
            cfg_reg.rpm_min          <= RST_RPM_MIN;
            cfg_reg.rpm_max          <= RST_RPM_MAX;
            cfg_reg.min_step_rpm     <= RST_MIN_STEP_RPM;
            cfg_reg.hold_ms          <= RST_HOLD_MS;
            cfg_reg.sample_period_ms <= RST_SAMPLE_MS;
            cfg_reg.device_id        <= RST_DEVICE_ID;
            cfg_reg.start_rpm        <= RST_START_RPM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: sampling, smoothing, speed decisions, run pin handling
    svf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .samples   (samples),
        .push      (fifo_push),
        .push_desc (fifo_in),
        .q_full    (fifo_full)
    );

    // descriptor queue decouples decision making from byte output
    svf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_in),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_out),
        .empty     (fifo_empty)
    );

    // back: byte serialiser with crc
    svf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .device_id (cfg_reg.device_id),
        .desc      (fifo_out),
        .q_empty   (fifo_empty),
        .pop       (fifo_pop),
        .frames    (frames)
    );

    // queue never overrun by the sequencer
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_push && fifo_full))
        else $error("descriptor pushed into full queue");

    // serialiser never reads an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_pop && fifo_empty))
        else $error("descriptor popped from empty queue");

    // a sample's last result is always the closing crc byte of a frame
    a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (frames.valid && frames.last) |-> frames.frame_end)
        else $error("last marked on a byte that does not close a frame");

    // no new sample is taken while the sequencer still holds back a frame
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |-> !u_front.pend_valid_reg)
        else $error("sample accepted with a frame still held back");

endmodule

/* dv/pwm_spindle_speed_to_vfd_frames_tb.sv */
// ---------------------------------------------------------------------------
// pwm_spindle_speed_to_vfd_frames_tb: self-checking bench for the frame converter
// drives pulse samples and register writes, predicts every frame byte with a
// behavioural model of the speed filter, hold-off logic and crc16, and checks
// each output transaction against it in order
// ---------------------------------------------------------------------------
module pwm_spindle_speed_to_vfd_frames_tb;
    import svf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no transaction on any channel before the run is abandoned
    localparam int STALL_LIMIT = 3000;
    // long receiver hold-off, long enough to fill the output queue
    localparam int HOLD_CYCLES = 400;
    // a sample with no frames can still be in the sequencer this long
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [7:0]  pulse_width;
        logic        pulse_level;
        logic        run_level;
    } sample_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       last;
    } wire_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    svf_sample_if sample_ch();
    svf_frame_if  frame_ch();
    svf_cfg_if    cfg_ch();

    pwm_spindle_speed_to_vfd_frames i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .frames  (frame_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // stimulus and expectation stores
    sample_t    sample_q[$];
    wire_byte_t frame_q[$];

    // idling percentages and receiver hold-off requests, set by the sequence
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    int errors       = 0;
    int samples_in   = 0;
    int bytes_out    = 0;
    int frames_out   = 0;
    int reg_writes   = 0;
    int stall_cycles = 0;

    // stimulus generator state: current time stamp and run pin level
    logic [31:0] stamp   = 0;
    logic        run_gen = 0;

    // speed model: register copies and controller state
    cfg_regs_t   reg_model;
    logic [31:0] sample_stamp;
    logic [31:0] update_stamp;
    logic [17:0] smooth_rpm;
    logic [15:0] cmd_rpm;
    logic        drive_running;
    logic        pin_seen_model;
    logic [15:0] crc_run;

    // ---------------------------------------------------------------------
    // speed model
    // ---------------------------------------------------------------------

    // one frame byte onto the expectation store; the crc high byte is not folded in
    function automatic void emit_byte(input logic [7:0] b, input logic fend);
        wire_byte_t e;
        if (!fend)
        begin
            crc_run = crc_run ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
            begin
                if (crc_run[0])
                    crc_run = (crc_run >> 1) ^ CRC_POLY;
                else
                    crc_run = crc_run >> 1;
            end
        end
        e.frame_byte = b;
        e.frame_end  = fend;
        e.last       = 1'b0;
        frame_q.push_back(e);
    endfunction

    // address, command, length, data, then crc low and high
    function automatic void queue_frame(input logic [7:0] cmd, input logic two,
                                        input logic [7:0] d0, input logic [7:0] d1);
        logic [15:0] crc;
        crc_run = CRC_INIT;
        emit_byte(reg_model.device_id, 1'b0);
        emit_byte(cmd, 1'b0);
        emit_byte(two ? 8'd2 : 8'd1, 1'b0);
        emit_byte(d0, 1'b0);
        if (two)
            emit_byte(d1, 1'b0);
        crc = crc_run;
        emit_byte(crc[7:0], 1'b0);
        emit_byte(crc[15:8], 1'b1);
    endfunction

    // hold-off, running flag and minimum step decide whether a speed frame goes out
    function automatic void speed_request(input logic [31:0] now, input logic [15:0] v);
        logic [31:0] gap;
        int          diff;
        int          drive_freq;
        gap = now - update_stamp;
        if (gap < {16'd0, reg_model.hold_ms})
            return;
        update_stamp = now;
        if (!drive_running)
            return;
        diff = int'(cmd_rpm) - int'(v);
        if (diff < 0)
            diff = -diff;
        if (diff < int'(reg_model.min_step_rpm))
            return;
        cmd_rpm    = v;
        drive_freq = int'(v) * 5 / 3;
        if (drive_freq > 65535)
            drive_freq = 65535;
        queue_frame(CMD_SPEED, 1'b1, drive_freq[15:8], drive_freq[7:0]);
    endfunction

    function automatic void predict_sample(input sample_t s);
        logic [31:0] elapsed;
        logic [7:0]  width;
        int          raw;
        int          delta;
        int          n0;
        wire_byte_t  tail;
        n0      = frame_q.size();
        elapsed = s.now_ms - sample_stamp;
        if (elapsed > {16'd0, reg_model.sample_period_ms})
        begin
            sample_stamp = s.now_ms;
            // widths past the timeout count as no edge seen
            width = ({8'd0, s.pulse_width} > PULSE_TIMEOUT_US) ? 8'd0 : s.pulse_width;
            if (width == 0)
                speed_request(s.now_ms, s.pulse_level ? reg_model.rpm_max : reg_model.rpm_min);
            else
            begin
                raw = int'(reg_model.rpm_min) + int'(reg_model.rpm_per_us) * int'(width);
                if (raw > 'h3FFFF)
                    raw = 'h3FFFF;
                // signed division truncates toward zero
                delta      = (raw - int'(smooth_rpm)) / FILTER_DIVISOR;
                smooth_rpm = 18'(int'(smooth_rpm) + delta);
                speed_request(s.now_ms, (smooth_rpm > 18'h0FFFF) ? 16'hFFFF : smooth_rpm[15:0]);
            end
        end
        if (s.run_level != pin_seen_model)
        begin
            pin_seen_model = s.run_level;
            if (s.run_level)
            begin
                drive_running = 1'b0;
                queue_frame(CMD_CONTROL, 1'b0, CTL_STOP, 8'h00);
            end
            else
            begin
                drive_running = 1'b1;
                queue_frame(CMD_STATUS, 1'b0, STATUS_DATA, 8'h00);
                update_stamp = 0;
                speed_request(s.now_ms, reg_model.start_rpm);
                queue_frame(CMD_CONTROL, 1'b0, CTL_RUN, 8'h00);
            end
        end
        if (frame_q.size() > n0)
        begin
            tail      = frame_q.pop_back();
            tail.last = 1'b1;
            frame_q.push_back(tail);
        end
    endfunction

    // ---------------------------------------------------------------------
    // sample driver: offers queued items, idles at random between them
    // ---------------------------------------------------------------------
    sample_t next_item;

    always @(posedge clk)
    begin
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = sample_q.pop_front();
                sample_ch.valid       <= 1'b1;
                sample_ch.now_ms      <= next_item.now_ms;
                sample_ch.pulse_width <= next_item.pulse_width;
                sample_ch.pulse_level <= next_item.pulse_level;
                sample_ch.run_level   <= next_item.run_level;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // frame receiver: random ready, plus a long hold-off on request
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            frame_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            frame_ch.ready <= 1'b0;
            hold_left      <= hold_left - 1;
        end
        else if (hold_taken != hold_asked)
        begin
            hold_taken     <= hold_asked;
            hold_left      <= HOLD_CYCLES;
            frame_ch.ready <= 1'b0;
        end
        else
            frame_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------------
    // monitor: predict on every sample transaction, then check frame bytes
    // ---------------------------------------------------------------------
    sample_t    taken_item;
    wire_byte_t want_byte;
    wire_byte_t seen_byte;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // predict first so a same-edge result would find its expectation
            if (sample_ch.valid && sample_ch.ready)
            begin
                taken_item.now_ms      = sample_ch.now_ms;
                taken_item.pulse_width = sample_ch.pulse_width;
                taken_item.pulse_level = sample_ch.pulse_level;
                taken_item.run_level   = sample_ch.run_level;
                predict_sample(taken_item);
                samples_in++;
            end
            if (frame_ch.valid && frame_ch.ready)
            begin
                seen_byte.frame_byte = frame_ch.frame_byte;
                seen_byte.frame_end  = frame_ch.frame_end;
                seen_byte.last       = frame_ch.last;
                bytes_out++;
                if (seen_byte.frame_end)
                    frames_out++;
                if (frame_q.size() == 0)
                begin
                    $display("%0t: unexpected frame byte %h frame_end %b last %b", $time,
                             seen_byte.frame_byte, seen_byte.frame_end, seen_byte.last);
                    errors++;
                end
                else
                begin
                    want_byte = frame_q.pop_front();
                    if (seen_byte.frame_byte !== want_byte.frame_byte)
                    begin
                        $display("%0t: frame_byte expected %h actual %h", $time,
                                 want_byte.frame_byte, seen_byte.frame_byte);
                        errors++;
                    end
                    if (seen_byte.frame_end !== want_byte.frame_end)
                    begin
                        $display("%0t: frame_end expected %b actual %b", $time,
                                 want_byte.frame_end, seen_byte.frame_end);
                        errors++;
                    end
                    if (seen_byte.last !== want_byte.last)
                    begin
                        $display("%0t: last expected %b actual %b", $time,
                                 want_byte.last, seen_byte.last);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // watchdog: any transaction on any channel restarts the count
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((sample_ch.valid && sample_ch.ready) || (frame_ch.valid && frame_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d frame bytes outstanding",
                     $time, STALL_LIMIT, frame_q.size());
            $display("pwm_spindle_speed_to_vfd_frames_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ---------------------------------------------------------------------
    // sequence helpers
    // ---------------------------------------------------------------------
    task automatic add_sample(input logic [31:0] now, input logic [7:0] pw,
                              input logic plev, input logic rlev);
        sample_t s;
        s.now_ms      = now;
        s.pulse_width = pw;
        s.pulse_level = plev;
        s.run_level   = rlev;
        sample_q.push_back(s);
        stamp   = now;
        run_gen = rlev;
    endtask

    // mostly steady time steps with random widths and occasional run pin
    // changes; a few time jumps stand in for noise
    task automatic add_random(input int count, input int span);
        logic [31:0] now;
        logic [7:0]  pw;
        int          r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 5)
                now = $urandom;
            else
                now = stamp + $urandom_range(span);
            r = $urandom_range(99);
            if (r < 6)
                pw = 8'd0;
            else if (r < 10)
                pw = 8'($urandom_range(255, 252));
            else if (r < 20)
                pw = 8'($urandom_range(255));
            else
                pw = 8'($urandom_range(252, 1));
            add_sample(now, pw, 1'($urandom_range(1)),
                       ($urandom_range(99) < 8) ? ~run_gen : run_gen);
        end
    endtask

    // wait for every sample to go in and every expected byte to come out
    task automatic settle(input int extra);
        while (sample_q.size() != 0 || sample_ch.valid || frame_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_RPM_PER_US:   reg_model.rpm_per_us       = val[9:0];
            CFG_RPM_MIN:      reg_model.rpm_min          = val;
            CFG_RPM_MAX:      reg_model.rpm_max          = val;
            CFG_MIN_STEP_RPM: reg_model.min_step_rpm     = val;
            CFG_HOLD_MS:      reg_model.hold_ms          = val;
            CFG_SAMPLE_MS:    reg_model.sample_period_ms = val;
            CFG_DEVICE_ID:    reg_model.device_id        = val[7:0];
            CFG_START_RPM:    reg_model.start_rpm        = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // every register, back to back, valid dropped only after the last one
    task automatic apply_config(input logic [9:0] gain, input logic [15:0] rmin,
                                input logic [15:0] rmax, input logic [15:0] step,
                                input logic [15:0] hold, input logic [15:0] period,
                                input logic [7:0] dev, input logic [15:0] start);
        write_reg(CFG_RPM_PER_US, {6'd0, gain});
        write_reg(CFG_RPM_MIN, rmin);
        write_reg(CFG_RPM_MAX, rmax);
        write_reg(CFG_MIN_STEP_RPM, step);
        write_reg(CFG_HOLD_MS, hold);
        write_reg(CFG_SAMPLE_MS, period);
        write_reg(CFG_DEVICE_ID, {8'd0, dev});
        write_reg(CFG_START_RPM, start);
        cfg_ch.valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        // every input known from time zero
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.now_ms      = 0;
        sample_ch.pulse_width = 0;
        sample_ch.pulse_level = 1'b0;
        sample_ch.run_level   = 1'b0;
        frame_ch.ready        = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_RPM_PER_US;
        cfg_ch.data           = 0;

        // model starts from the register defaults and a stopped drive
        reg_model.rpm_per_us       = RST_RPM_PER_US;
        reg_model.rpm_min          = RST_RPM_MIN;
        reg_model.rpm_max          = RST_RPM_MAX;
        reg_model.min_step_rpm     = RST_MIN_STEP_RPM;
        reg_model.hold_ms          = RST_HOLD_MS;
        reg_model.sample_period_ms = RST_SAMPLE_MS;
        reg_model.device_id        = RST_DEVICE_ID;
        reg_model.start_rpm        = RST_START_RPM;
        sample_stamp   = 0;
        update_stamp   = 0;
        smooth_rpm     = 0;
        cmd_rpm        = 0;
        drive_running  = 1'b0;
        pin_seen_model = 1'b0;
        crc_run        = CRC_INIT;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset defaults
        add_sample(32'd50, 8'd0, 1'b0, 1'b1);       // run pin high: stop frame only
        add_sample(32'd1500, 8'd0, 1'b1, 1'b0);     // start sequence with start speed
        add_sample(32'd2600, 8'd252, 1'b0, 1'b0);   // widest valid pulse, filtered speed
        add_sample(32'd3700, 8'd253, 1'b1, 1'b0);   // past timeout, pin high: max speed
        add_sample(32'd4800, 8'd255, 1'b0, 1'b0);   // past timeout, pin low: min speed
        add_sample(32'd4850, 8'd100, 1'b1, 1'b0);   // inside sample period: no frames
        add_sample(32'd4900, 8'd1, 1'b0, 1'b0);     // exactly one period: still no sample
        add_sample(32'd4901, 8'd1, 1'b0, 1'b0);     // sampled but held off
        settle(SETTLE_CYCLES);

        // directed, top of every register range
        apply_config(10'd1023, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 8'hFF, 16'hFFFF);
        @(negedge clk);
        // raw speed saturates, smoothed value climbs past 16 bits, frequency clips
        for (int i = 0; i < 6; i++)
            add_sample(32'd5000 + 32'(i) * 32'd1000, 8'd252, 1'b0, 1'b0);
        add_sample(32'd12000, 8'd0, 1'b1, 1'b0);
        add_sample(32'd12000, 8'd0, 1'b1, 1'b0);    // no time elapsed: nothing
        add_sample(32'hFFFF_FFF0, 8'd10, 1'b1, 1'b1);  // speed frame then stop
        add_sample(32'h0000_0005, 8'd0, 1'b0, 1'b0);   // time wraps, restart
        settle(SETTLE_CYCLES);

        // directed, bottom of the ranges with the longest sample period
        apply_config(10'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 8'h00, 16'd0);
        @(negedge clk);
        add_sample(32'd105, 8'd200, 1'b0, 1'b0);
        add_sample(32'd70105, 8'd200, 1'b0, 1'b0);  // smoothed value falls toward zero
        add_sample(32'd140106, 8'd0, 1'b1, 1'b1);
        add_sample(32'd140107, 8'd0, 1'b0, 1'b0);
        settle(SETTLE_CYCLES);

        // random, slow-ish sender and very slow receiver, with a long hold-off
        send_idle_pct = 37;
        recv_idle_pct = 83;
        apply_config(10'($urandom_range(1023)), 16'($urandom_range(20000)),
                     16'($urandom_range(65535)), 16'($urandom_range(400)),
                     16'($urandom_range(60)), 16'($urandom_range(30)),
                     8'($urandom_range(255)), 16'($urandom_range(65535)));
        @(negedge clk);
        add_random(90, 80);
        hold_asked++;
        settle(SETTLE_CYCLES);

        // random, roles swapped, sender waits for the drive to drain between bursts
        send_idle_pct = 83;
        recv_idle_pct = 37;
        apply_config(10'($urandom_range(1023)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)), 16'($urandom_range(2000)),
                     16'($urandom_range(40)), 16'($urandom_range(20)),
                     8'($urandom_range(255)), 16'($urandom_range(65535)));
        for (int b = 0; b < 3; b++)
        begin
            @(negedge clk);
            add_random(30, 60);
            settle(0);
        end
        settle(SETTLE_CYCLES);

        // random, full rate, defaults written back explicitly
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(RST_RPM_PER_US, RST_RPM_MIN, RST_RPM_MAX, RST_MIN_STEP_RPM,
                     RST_HOLD_MS, RST_SAMPLE_MS, RST_DEVICE_ID, RST_START_RPM);
        @(negedge clk);
        add_random(100, 2500);
        settle(SETTLE_CYCLES);

        $display("covered %0d sample transactions, %0d frame bytes in %0d frames,",
                 samples_in, bytes_out, frames_out);
        $display("%0d register writes across five settings, %0d mismatches",
                 reg_writes, errors);
        if (errors == 0)
            $display("pwm_spindle_speed_to_vfd_frames_tb: done, clean");
        else
            $display("pwm_spindle_speed_to_vfd_frames_tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
src/svf_pkg.sv
src/svf_ifs.sv
src/svf_front.sv
src/svf_fifo.sv
src/svf_back.sv
src/pwm_spindle_speed_to_vfd_frames.sv
dv/pwm_spindle_speed_to_vfd_frames_tb.sv
